FILE: rtl/core/btcr_pkg.sv
package btcr_pkg;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_CHAR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_CHAR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd3;

   localparam logic ACTION_DRAW = 1'b0;
   localparam logic ACTION_LOAD = 1'b1;

   localparam logic [12:0] SCREEN_MAX = 13'd4096;

   localparam logic [7:0]  FIRST_CHAR_RST    = 8'd32;
   localparam logic [7:0]  LAST_CHAR_RST     = 8'd126;
   localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd320;
   localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd240;

   typedef logic        [7:0]  code_type;
   typedef logic signed [15:0] coord_type;
   typedef logic        [15:0] colour_type;
   typedef logic        [12:0] dim_type;
   typedef logic        [11:0] pix_type;

endpackage

FILE: rtl/core/btcr_chan_if.sv
interface btcr_req_if;
   logic                  valid;
   logic                  ready;
   logic                  action;
   btcr_pkg::code_type    char_code;
   logic [2:0]            glyph_row;
   logic [7:0]            row_bits;
   logic                  start_string;
   btcr_pkg::coord_type   pos_x;
   btcr_pkg::coord_type   pos_y;
   btcr_pkg::colour_type  ink_colour;
   btcr_pkg::colour_type  paper_colour;

   modport source (
      output valid, action, char_code, glyph_row, row_bits, start_string,
             pos_x, pos_y, ink_colour, paper_colour,
      input  ready
   );
   modport sink (
      input  valid, action, char_code, glyph_row, row_bits, start_string,
             pos_x, pos_y, ink_colour, paper_colour,
      output ready
   );
endinterface

interface btcr_rsp_if;
   logic                  valid;
   logic                  ready;
   btcr_pkg::pix_type     span_y;
   btcr_pkg::pix_type     span_x_first;
   btcr_pkg::dim_type     span_x_end;
   logic [7:0]            ink_mask;
   logic [3:0]            ink_count;
   btcr_pkg::colour_type  span_paper;
   btcr_pkg::colour_type  span_ink;
   logic                  last_span;

   modport source (
      output valid, span_y, span_x_first, span_x_end, ink_mask, ink_count,
             span_paper, span_ink, last_span,
      input  ready
   );
   modport sink (
      input  valid, span_y, span_x_first, span_x_end, ink_mask, ink_count,
             span_paper, span_ink, last_span,
      output ready
   );
endinterface

FILE: rtl/core/bitmap_text_cell_renderer_top.sv
// Load item: the glyph row is written at the accepting edge if the code maps
// to a glyph slot and the row is below GLYPH_H; the block stays ready.
// Draw item: a setup state follows acceptance, then for each visible cell row
// a glyph store read state and a send state that holds the span until it is
// transferred; the single glyph store read port and the row sequencer set this order.
// Reset (synchronous): sequencer idle, cursor zero, configuration registers to defaults.
// The glyph store is not cleared.
module bitmap_text_cell_renderer_top #(
   parameter int unsigned CELL_W      = 8,
   parameter int unsigned CELL_H      = 8,
   parameter int unsigned GLYPH_W     = 8,
   parameter int unsigned GLYPH_H     = 8,
   parameter int unsigned GLYPH_SLOTS = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   btcr_req_if.sink                           req_ch,
   btcr_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [btcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [btcr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned DEPTH  = GLYPH_SLOTS * GLYPH_H;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
   localparam int unsigned ROW_W  = (CELL_H > 1) ? $clog2(CELL_H) : 1;
   localparam int unsigned ALIGN  = 8 - GLYPH_W;

   localparam logic [8:0]         SLOTS_9   = 9'(GLYPH_SLOTS);
   localparam logic [5:0]         GLYPH_H_6 = 6'(GLYPH_H);
   localparam logic [ADDR_W-1:0]  GLYPH_H_A = ADDR_W'(GLYPH_H);
   localparam logic [15:0]        CELL_W_16 = 16'(CELL_W);
   localparam logic signed [17:0] CELL_W_S  = 18'(CELL_W);
   localparam logic signed [17:0] CELL_H_S  = 18'(CELL_H);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   logic [1:0]              state_ff, state_in;
   btcr_pkg::code_type      first_char_ff, last_char_ff;
   btcr_pkg::dim_type       screen_width_ff, screen_height_ff;
   btcr_pkg::coord_type     cursor_ff, cursor_in;

   btcr_pkg::coord_type     cx_ff, cy_ff;
   btcr_pkg::colour_type    ink_ff, paper_ff;
   logic                    has_glyph_ff;
   logic [ADDR_W-1:0]       base_ff;
   btcr_pkg::pix_type       xa_ff, y_ff;
   btcr_pkg::dim_type       xb_ff, yb_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [7:0]              colmask_ff;
   logic [7:0]              rd_data_ff;

   logic [7:0]              glyph_mem [DEPTH];

   logic                    req_xfer, rsp_xfer;
   logic [7:0]              code_off;
   logic                    glyph_hit;
   logic [SLOT_W-1:0]       slot;
   logic [ADDR_W-1:0]       slot_base;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr, rd_addr;
   btcr_pkg::coord_type     cur;

   btcr_pkg::dim_type       sw, sh;
   logic signed [17:0]      x0, x1, y0, y1, sw_s, sh_s, xa, xb, ya, yb, row0;
   logic signed [17:0]      px [8];
   logic [7:0]              colmask;
   logic                    visible;

   logic                    rd_ok;
   logic [7:0]              aligned, mask;
   logic                    last;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;

   // glyph lookup
   assign code_off  = req_ch.char_code - first_char_ff;
   assign glyph_hit = (req_ch.char_code >= first_char_ff) &&
                      (req_ch.char_code <= last_char_ff) &&
                      ({1'b0, code_off} < SLOTS_9);
   assign slot      = code_off[SLOT_W-1:0];
   assign slot_base = ADDR_W'(ADDR_W'(slot) * GLYPH_H_A);
   assign mem_waddr = slot_base + ADDR_W'(req_ch.glyph_row);
   assign mem_we    = req_xfer && (req_ch.action == btcr_pkg::ACTION_LOAD) && glyph_hit &&
                      ({3'b000, req_ch.glyph_row} < GLYPH_H_6);
   assign rd_addr   = base_ff + ADDR_W'(row_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_mem[mem_waddr] <= req_ch.row_bits;
      end
      rd_data_ff <= glyph_mem[rd_addr];
   end

   assign cur = req_ch.start_string ? req_ch.pos_x : cursor_ff;

   always_comb begin
      cursor_in = cursor_ff;
      if (req_xfer && (req_ch.action == btcr_pkg::ACTION_DRAW)) begin
         cursor_in = cur + CELL_W_16;
      end
   end

   // clipping
   assign sw   = (screen_width_ff  > btcr_pkg::SCREEN_MAX) ? btcr_pkg::SCREEN_MAX
                                                          : screen_width_ff;
   assign sh   = (screen_height_ff > btcr_pkg::SCREEN_MAX) ? btcr_pkg::SCREEN_MAX
                                                          : screen_height_ff;
   assign sw_s = signed'({5'b00000, sw});
   assign sh_s = signed'({5'b00000, sh});
   assign x0   = 18'(cx_ff);
   assign y0   = 18'(cy_ff);
   assign x1   = x0 + CELL_W_S;
   assign y1   = y0 + CELL_H_S;
   assign xa   = (x0 < 0) ? 18'sd0 : x0;
   assign ya   = (y0 < 0) ? 18'sd0 : y0;
   assign xb   = (x1 > sw_s) ? sw_s : x1;
   assign yb   = (y1 > sh_s) ? sh_s : y1;
   assign row0 = ya - y0;
   assign visible = (xa < xb) && (ya < yb);

   always_comb begin
      colmask = '0;
      for (int col = 0; col < 8; col++) begin
         px[col] = x0 + 18'(col);
         colmask[7 - col] = (col < GLYPH_W) && (col < CELL_W) &&
                            (px[col] >= 0) && (px[col] < sw_s);
      end
   end

   // span assembly
   assign rd_ok   = has_glyph_ff && (6'(row_ff) < GLYPH_H_6);
   assign aligned = 8'(rd_data_ff << ALIGN);
   assign mask    = rd_ok ? (aligned & colmask_ff) : 8'h00;
   assign last    = ((13'(y_ff) + 13'd1) == yb_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_ch.action == btcr_pkg::ACTION_DRAW)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = visible ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_xfer) begin
               state_in = last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cursor_ff        <= '0;
         first_char_ff    <= btcr_pkg::FIRST_CHAR_RST;
         last_char_ff     <= btcr_pkg::LAST_CHAR_RST;
         screen_width_ff  <= btcr_pkg::SCREEN_WIDTH_RST;
         screen_height_ff <= btcr_pkg::SCREEN_HEIGHT_RST;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         if (csr_we) begin
            unique case (csr_index)
               btcr_pkg::CSR_FIRST_CHAR:    first_char_ff    <= csr_wdata[7:0];
               btcr_pkg::CSR_LAST_CHAR:     last_char_ff     <= csr_wdata[7:0];
               btcr_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
               btcr_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cx_ff        <= cur;
         cy_ff        <= req_ch.pos_y;
         ink_ff       <= req_ch.ink_colour;
         paper_ff     <= req_ch.paper_colour;
         has_glyph_ff <= glyph_hit;
         base_ff      <= slot_base;
      end
      if (state_ff == ST_SETUP) begin
         xa_ff      <= xa[11:0];
         xb_ff      <= xb[12:0];
         y_ff       <= ya[11:0];
         yb_ff      <= yb[12:0];
         row_ff     <= row0[ROW_W-1:0];
         colmask_ff <= colmask;
      end else if ((state_ff == ST_SEND) && rsp_xfer) begin
         y_ff   <= y_ff + 12'd1;
         row_ff <= row_ff + ROW_W'(1);
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE) && !reset;
   assign rsp_ch.valid        = (state_ff == ST_SEND);
   assign rsp_ch.span_y       = y_ff;
   assign rsp_ch.span_x_first = xa_ff;
   assign rsp_ch.span_x_end   = xb_ff;
   assign rsp_ch.ink_mask     = mask;
   assign rsp_ch.ink_count    = 4'($countones(mask));
   assign rsp_ch.span_paper   = paper_ff;
   assign rsp_ch.span_ink     = ink_ff;
   assign rsp_ch.last_span    = last;

   a_load_stays_ready: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_ch.action == btcr_pkg::ACTION_LOAD)) |=> req_ch.ready)
      else $error("load transfer left the block busy");

   a_draw_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_ch.action == btcr_pkg::ACTION_DRAW)) |=> !req_ch.ready)
      else $error("draw transfer did not start the sequencer");

   a_span_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ({1'b0, rsp_ch.span_x_first} < rsp_ch.span_x_end))
      else $error("span with empty x range");

   a_last_ends_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_ch.last_span) |=> (req_ch.ready && !rsp_ch.valid))
      else $error("sequencer did not return to idle after last span");

   a_mid_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_ch.last_span) |=> !req_ch.ready)
      else $error("sequencer went idle before last span");

endmodule
